### rtl/imrot_pkg.sv
// ----------------------------------------------------------------------------
// imrot_pkg
// Shared types and constants of the nearest-neighbor image rotation block.
// ----------------------------------------------------------------------------
package imrot_pkg;

   localparam int COORD_W   = 6;
   localparam int DIM_W     = 7;
   localparam int ANGLE_W   = 16;
   localparam int DELTA_W   = COORD_W + 2;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int CSR_IDX_W = 4;
   localparam int LATENCY   = 8;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE    = 4'd3;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 7'd64;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 7'd64;
   localparam logic [ANGLE_W-1:0] COS_RESET    = 16'd16384;
   localparam logic [ANGLE_W-1:0] SIN_RESET    = 16'd0;

   typedef struct packed {
      logic wr;
      logic rd;
      logic hit;
   } ctrl_type;

endpackage

### rtl/imrot_transform.sv
// ----------------------------------------------------------------------------
// imrot_transform
// Five-stage coordinate pipeline: offset, multiply, sum, bounds and rounding,
// clamp and frame store address.
// ----------------------------------------------------------------------------
module imrot_transform #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int FRAC_BITS  = 14,
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_vld,
   input  logic                                in_fetch,
   input  logic [imrot_pkg::COORD_W-1:0]       in_x,
   input  logic [imrot_pkg::COORD_W-1:0]       in_y,
   input  logic [imrot_pkg::PIX_W-1:0]         in_pix,
   input  logic [imrot_pkg::DIM_W-1:0]         w_eff,
   input  logic [imrot_pkg::DIM_W-1:0]         h_eff,
   input  logic signed [imrot_pkg::ANGLE_W-1:0] cos_val,
   input  logic signed [imrot_pkg::ANGLE_W-1:0] sin_val,
   output imrot_pkg::ctrl_type                 ctrl_out,
   output logic [AW-1:0]                       addr_out,
   output logic [imrot_pkg::PIX_W-1:0]         pix_out
);
   import imrot_pkg::*;

   localparam int PROD_W = ANGLE_W + DELTA_W;
   localparam int BASE_W = FRAC_BITS + DIM_W + 1;
   localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 2;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

   logic [COORD_W-1:0] cx, cy;
   logic signed [SUM_W-1:0] cx_l, cy_l, wl, hl;

   // stage 1: offsets from the center
   logic                       s1_vld_ff, s1_fetch_ff, s1_wok_ff;
   logic [COORD_W-1:0]         s1_x_ff, s1_y_ff;
   logic [PIX_W-1:0]           s1_pix_ff;
   logic signed [DELTA_W-1:0]  s1_dx_ff, s1_dy_ff;
   // stage 2: products
   logic                       s2_vld_ff, s2_fetch_ff, s2_wok_ff;
   logic [COORD_W-1:0]         s2_x_ff, s2_y_ff;
   logic [PIX_W-1:0]           s2_pix_ff;
   logic signed [PROD_W-1:0]   s2_cdx_ff, s2_sdy_ff, s2_sdx_ff, s2_cdy_ff;
   // stage 3: rotated point
   logic                       s3_vld_ff, s3_fetch_ff, s3_wok_ff;
   logic [COORD_W-1:0]         s3_x_ff, s3_y_ff;
   logic [PIX_W-1:0]           s3_pix_ff;
   logic signed [SUM_W-1:0]    s3_rx_ff, s3_ry_ff;
   // stage 4: bounds and rounding
   logic                       s4_vld_ff, s4_fetch_ff, s4_wok_ff, s4_inside_ff;
   logic [COORD_W-1:0]         s4_x_ff, s4_y_ff;
   logic [PIX_W-1:0]           s4_pix_ff;
   logic [DIM_W-1:0]           s4_sx_ff, s4_sy_ff;
   // stage 5: address
   ctrl_type                   s5_ctrl_ff, s5_ctrl_in;
   logic [AW-1:0]              s5_addr_ff, s5_addr_in;
   logic [PIX_W-1:0]           s5_pix_ff;

   logic [SUM_W-1:0] rnd_x, rnd_y;
   logic [DIM_W-1:0] ax, ay;

   assign cx   = w_eff[DIM_W-1:1];
   assign cy   = h_eff[DIM_W-1:1];
   assign cx_l = SUM_W'({cx, {FRAC_BITS{1'b0}}});
   assign cy_l = SUM_W'({cy, {FRAC_BITS{1'b0}}});
   assign wl   = SUM_W'({w_eff, {FRAC_BITS{1'b0}}});
   assign hl   = SUM_W'({h_eff, {FRAC_BITS{1'b0}}});

   assign rnd_x = s3_rx_ff + HALF;
   assign rnd_y = s3_ry_ff + HALF;

   always_comb begin
      if (s4_fetch_ff) begin
         ax = (s4_sx_ff >= w_eff) ? w_eff - 7'd1 : s4_sx_ff;
         ay = (s4_sy_ff >= h_eff) ? h_eff - 7'd1 : s4_sy_ff;
      end else begin
         ax = DIM_W'(s4_x_ff);
         ay = DIM_W'(s4_y_ff);
      end
      s5_addr_in = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);
      s5_ctrl_in.wr  = s4_vld_ff && !s4_fetch_ff && s4_wok_ff;
      s5_ctrl_in.rd  = s4_vld_ff && s4_fetch_ff;
      s5_ctrl_in.hit = s4_inside_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_ctrl_ff <= '0;
      end else begin
         s1_vld_ff  <= in_vld;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_ctrl_ff <= s5_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_fetch_ff <= in_fetch;
      s1_wok_ff   <= (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);
      s1_x_ff     <= in_x;
      s1_y_ff     <= in_y;
      s1_pix_ff   <= in_pix;
      s1_dx_ff    <= signed'({2'b00, in_x} - {2'b00, cx});
      s1_dy_ff    <= signed'({2'b00, in_y} - {2'b00, cy});

      s2_fetch_ff <= s1_fetch_ff;
      s2_wok_ff   <= s1_wok_ff;
      s2_x_ff     <= s1_x_ff;
      s2_y_ff     <= s1_y_ff;
      s2_pix_ff   <= s1_pix_ff;
      s2_cdx_ff   <= PROD_W'(cos_val) * PROD_W'(s1_dx_ff);
      s2_sdy_ff   <= PROD_W'(sin_val) * PROD_W'(s1_dy_ff);
      s2_sdx_ff   <= PROD_W'(sin_val) * PROD_W'(s1_dx_ff);
      s2_cdy_ff   <= PROD_W'(cos_val) * PROD_W'(s1_dy_ff);

      s3_fetch_ff <= s2_fetch_ff;
      s3_wok_ff   <= s2_wok_ff;
      s3_x_ff     <= s2_x_ff;
      s3_y_ff     <= s2_y_ff;
      s3_pix_ff   <= s2_pix_ff;
      s3_rx_ff    <= SUM_W'(s2_cdx_ff) - SUM_W'(s2_sdy_ff) + cx_l;
      s3_ry_ff    <= SUM_W'(s2_sdx_ff) + SUM_W'(s2_cdy_ff) + cy_l;

      s4_fetch_ff  <= s3_fetch_ff;
      s4_wok_ff    <= s3_wok_ff;
      s4_x_ff      <= s3_x_ff;
      s4_y_ff      <= s3_y_ff;
      s4_pix_ff    <= s3_pix_ff;
      s4_inside_ff <= !s3_rx_ff[SUM_W-1] && (s3_rx_ff < wl) &&
                      !s3_ry_ff[SUM_W-1] && (s3_ry_ff < hl);
      s4_sx_ff     <= rnd_x[FRAC_BITS +: DIM_W];
      s4_sy_ff     <= rnd_y[FRAC_BITS +: DIM_W];

      s5_addr_ff <= s5_addr_in;
      s5_pix_ff  <= s4_pix_ff;
   end

   assign ctrl_out = s5_ctrl_ff;
   assign addr_out = s5_addr_ff;
   assign pix_out  = s5_pix_ff;

endmodule

### rtl/imrot_store.sv
// ----------------------------------------------------------------------------
// imrot_store
// Frame store with registered read, and the result register that blanks
// points falling outside the image.
// ----------------------------------------------------------------------------
module imrot_store #(
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imrot_pkg::ctrl_type         ctrl_in,
   input  logic [AW-1:0]               addr,
   input  logic [imrot_pkg::PIX_W-1:0] wdata,
   output logic                        rsp_valid,
   output logic [imrot_pkg::PIX_W-1:0] rsp_pix,
   output logic                        rsp_inside
);
   import imrot_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_ff;
   logic             m1_rd_ff, m1_inside_ff;
   logic             out_vld_ff, out_inside_ff;
   logic [PIX_W-1:0] out_pix_ff;

   always_ff @(posedge clock) begin
      if (ctrl_in.wr) begin
         mem[addr] <= wdata;
      end
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_rd_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         m1_rd_ff   <= ctrl_in.rd;
         out_vld_ff <= m1_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_inside_ff  <= ctrl_in.hit;
      out_inside_ff <= m1_inside_ff;
      out_pix_ff    <= m1_inside_ff ? rd_ff : '0;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_pix    = out_pix_ff;
   assign rsp_inside = out_inside_ff;

endmodule

### rtl/image_rotate_nearest.sv
// ----------------------------------------------------------------------------
// image_rotate_nearest
// Nearest-neighbor rotation of an RGB frame store about the image center.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high and busy is low; busy
// is high only during reset. A load request writes one pixel and returns
// nothing; a fetch request returns one pixel as a one-cycle rsp_valid strobe,
// and one fetch per clock is sustained. A fetch passes through the input
// register, five coordinate stages (offset, multiply, sum, bounds and
// rounding, address), the frame store read register and the result register.
// The frame store takes one access per cycle, in request order, so a fetch
// sees every earlier load. Entries never loaded read as undefined. The user
// must write configuration only while no fetch is in flight; the block
// itself does not enforce it.
module image_rotate_nearest #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int FRAC_BITS  = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [imrot_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [imrot_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [imrot_pkg::CHAN_W-1:0]    req_in_red,
   input  logic [imrot_pkg::CHAN_W-1:0]    req_in_green,
   input  logic [imrot_pkg::CHAN_W-1:0]    req_in_blue,
   output logic                            rsp_valid,
   output logic [imrot_pkg::CHAN_W-1:0]    rsp_out_red,
   output logic [imrot_pkg::CHAN_W-1:0]    rsp_out_green,
   output logic [imrot_pkg::CHAN_W-1:0]    rsp_out_blue,
   output logic                            rsp_inside_res,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [imrot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [imrot_pkg::ANGLE_W-1:0]   csr_wdata
);
   import imrot_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic [DIM_W-1:0]          width_ff, height_ff;
   logic signed [ANGLE_W-1:0] cos_ff, sin_ff;
   logic [DIM_W-1:0]          w_eff, h_eff;

   logic               in_vld_ff, in_vld_in;
   logic               in_fetch_ff;
   logic [COORD_W-1:0] in_x_ff, in_y_ff;
   logic [PIX_W-1:0]   in_pix_ff;

   ctrl_type         st_ctrl;
   logic [AW-1:0]    st_addr;
   logic [PIX_W-1:0] st_pix;
   logic [PIX_W-1:0] rsp_pix;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign in_vld_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         cos_ff    <= COS_RESET;
         sin_ff    <= SIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_COS_ANGLE:    cos_ff    <= csr_wdata;
            CSR_SIN_ANGLE:    sin_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      priority if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_fetch_ff <= req_type == REQ_FETCH;
      in_x_ff     <= req_pos_x;
      in_y_ff     <= req_pos_y;
      in_pix_ff   <= {req_in_red, req_in_green, req_in_blue};
   end

   imrot_transform #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_transform (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld_ff),
      .in_fetch (in_fetch_ff),
      .in_x     (in_x_ff),
      .in_y     (in_y_ff),
      .in_pix   (in_pix_ff),
      .w_eff    (w_eff),
      .h_eff    (h_eff),
      .cos_val  (cos_ff),
      .sin_val  (sin_ff),
      .ctrl_out (st_ctrl),
      .addr_out (st_addr),
      .pix_out  (st_pix)
   );

   imrot_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (st_ctrl),
      .addr       (st_addr),
      .wdata      (st_pix),
      .rsp_valid  (rsp_valid),
      .rsp_pix    (rsp_pix),
      .rsp_inside (rsp_inside_res)
   );

   assign rsp_out_red   = rsp_pix[2*CHAN_W +: CHAN_W];
   assign rsp_out_green = rsp_pix[CHAN_W +: CHAN_W];
   assign rsp_out_blue  = rsp_pix[0 +: CHAN_W];

`ifndef ASSERT_OFF
   a_fetch_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_FETCH) |-> ##LATENCY rsp_valid)
      else $error("fetch request gave no result");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_LOAD) |-> ##LATENCY !rsp_valid)
      else $error("load request gave a result");

   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |->
      (rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0))
      else $error("outside point returned a colored pixel");
`endif

endmodule
